@@ rtl/lexical_token_scanner_defines.svh @@
// Assertion macros for the lexical token scanner.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef LEXICAL_TOKEN_SCANNER_DEFINES_SVH
`define LEXICAL_TOKEN_SCANNER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define LTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the cycle after.
`define LTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/lts_pkg.sv @@
// Shared types, codes and keyword table of the lexical token scanner.
// No dependencies.
package lts_pkg;

  localparam int MAX_TEXT   = 48;
  localparam int TXT_AW     = $clog2(MAX_TEXT);
  localparam int TXT_LEN_W  = $clog2(MAX_TEXT + 1);
  localparam logic [30:0] INT_SAT = 31'h7FFF_FFFF;

  // token kinds
  localparam logic [3:0] K_END    = 4'd0;
  localparam logic [3:0] K_IDENT  = 4'd1;
  localparam logic [3:0] K_KWORD  = 4'd2;
  localparam logic [3:0] K_SYMBOL = 4'd3;
  localparam logic [3:0] K_INT    = 4'd4;
  localparam logic [3:0] K_FLOAT  = 4'd5;
  localparam logic [3:0] K_CHAR   = 4'd6;
  localparam logic [3:0] K_NLCHAR = 4'd7;
  localparam logic [3:0] K_NULCH  = 4'd8;
  localparam logic [3:0] K_STRING = 4'd9;
  localparam logic [3:0] K_ERROR  = 4'd10;

  // error codes
  localparam logic [1:0] E_INVALID = 2'd0;
  localparam logic [1:0] E_LONG    = 2'd1;
  localparam logic [1:0] E_EOF     = 2'd2;

  // symbol codes
  localparam logic [4:0] Y_LBRACE = 5'd0;
  localparam logic [4:0] Y_RBRACE = 5'd1;
  localparam logic [4:0] Y_LPAREN = 5'd2;
  localparam logic [4:0] Y_RPAREN = 5'd3;
  localparam logic [4:0] Y_LBRACK = 5'd4;
  localparam logic [4:0] Y_RBRACK = 5'd5;
  localparam logic [4:0] Y_DOT    = 5'd6;
  localparam logic [4:0] Y_COMMA  = 5'd7;
  localparam logic [4:0] Y_SEMI   = 5'd8;
  localparam logic [4:0] Y_CARET  = 5'd9;
  localparam logic [4:0] Y_TILDE  = 5'd10;
  localparam logic [4:0] Y_STAR   = 5'd11;
  localparam logic [4:0] Y_MINUS  = 5'd12;
  localparam logic [4:0] Y_PLUS   = 5'd13;
  localparam logic [4:0] Y_SLASH  = 5'd14;
  localparam logic [4:0] Y_GT     = 5'd15;
  localparam logic [4:0] Y_GE     = 5'd16;
  localparam logic [4:0] Y_LT     = 5'd17;
  localparam logic [4:0] Y_LE     = 5'd18;
  localparam logic [4:0] Y_AMP    = 5'd19;
  localparam logic [4:0] Y_AND    = 5'd20;
  localparam logic [4:0] Y_OR     = 5'd21;
  localparam logic [4:0] Y_COLON  = 5'd22;
  localparam logic [4:0] Y_SCOPE  = 5'd23;
  localparam logic [4:0] Y_BANG   = 5'd24;
  localparam logic [4:0] Y_NE     = 5'd25;
  localparam logic [4:0] Y_ASSIGN = 5'd26;
  localparam logic [4:0] Y_EQ     = 5'd27;

  // keywords, right-justified, zero padded to seven bytes
  localparam logic [55:0] KW_TEXT [16] = '{
    56'("class"), 56'("data"), 56'("code"), 56'("intern"),
    56'("void"), 56'("char"), 56'("int"), 56'("float"),
    56'("bool"), 56'("if"), 56'("else"), 56'("while"),
    56'("for"), 56'("return"), 56'("delete"), 56'("new")
  };

  typedef struct packed {
    logic [3:0]  kind;
    logic [4:0]  sym;
    logic [30:0] ival;
    logic [3:0]  kw;
    logic [7:0]  ch;
    logic [15:0] lit;
    logic [1:0]  err;
  } tok_t;

  function automatic logic [2:0] kw_len(input logic [3:0] k);
    logic [55:0] w;
    logic [2:0]  n;
    w = KW_TEXT[k];
    n = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (w[8*i +: 8] != 8'd0) n = n + 3'd1;
    end
    return n;
  endfunction

  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] i);
    logic [55:0] w;
    logic [2:0]  n;
    logic [7:0]  r;
    w = KW_TEXT[k];
    n = kw_len(k);
    r = 8'd0;
    if (i < n) r = w[8*(n - 3'd1 - i) +: 8];
    return r;
  endfunction

  function automatic tok_t tok_kind(input logic [3:0] kind);
    tok_t t;
    t = '0;
    t.kind = kind;
    return t;
  endfunction

  function automatic tok_t tok_sym(input logic [4:0] code);
    tok_t t;
    t = '0;
    t.kind = K_SYMBOL;
    t.sym = code;
    return t;
  endfunction

  function automatic tok_t tok_err(input logic [1:0] code);
    tok_t t;
    t = '0;
    t.kind = K_ERROR;
    t.err = code;
    return t;
  endfunction

endpackage

@@ rtl/lts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lts_ram #(
  parameter int Width = 8,
  parameter int Depth = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/lexical_token_scanner.sv @@
// Top level of the lexical token scanner: lexer state machine, text sequencer,
// output register. Depends on lts_pkg, lts_ram and lexical_token_scanner_defines.svh.
//
//  channel  dir  tdata                          tuser        tlast
//  s_axis   in   source_byte                    -            end_of_input
//  m_axis   out  symbol..item_last (see port)   token_kind   token_last
//
// A byte that does not end a text run is handled on acceptance; its one or two result
// requests leave through the output register, one per cycle unless the output stalls.
// A text run of N characters is sent entry by entry: each buffer entry is read from
// the text RAM (one read port, registered read data) and then handed to the output.
// Input is not taken while a run or a second result is still pending, nor
// while the output register is full and stalled.
// Reset clears all control state; the text RAM needs no clearing, as only
// written entries are read.
`include "lexical_token_scanner_defines.svh"

module lexical_token_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte
  input  logic        s_axis_tlast,   // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [4:0] symbol_code, [35:5] int_value,
                                      // [39:36] keyword_index, [47:40] char_value,
                                      // [63:48] literal_index, [71:64] text_char,
                                      // [72] text_valid, [74:73] error_code,
                                      // [75] item_last, [79:76] zero
  output logic [3:0]  m_axis_tuser,   // token_kind
  output logic        m_axis_tlast    // token_last
);
  import lts_pkg::*;

  typedef enum logic [4:0] {
    S_START, S_IDENT, S_INT, S_FDOT, S_FLOAT, S_STR, S_CH_OPEN, S_CH_HELD,
    S_CH_ESC, S_CH_NL, S_CH_NUL, S_GT, S_LT, S_AMP, S_BAR, S_COLON, S_BANG,
    S_EQ, S_SLASH, S_CMT, S_CMT_STAR
  } scan_e;

  typedef enum logic [1:0] {M_IDLE, M_READ, M_WAIT, M_PEND} mode_e;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  // state
  mode_e                mode_q, mode_d;
  scan_e                scan_q, n_st;
  logic [TXT_LEN_W-1:0] tl_q, n_tl;
  logic [30:0]          acc_q, n_acc;
  logic [7:0]           held_q, n_held;
  logic [15:0]          lit_q, n_lit;
  logic [15:0]          kwm_q, n_kwm;
  tok_t                 run_tok_q, run_tok_d;
  logic [TXT_LEN_W-1:0] run_len_q, run_len_d;
  logic [TXT_AW-1:0]    idx_q, idx_d;
  tok_t                 pend_tok_q, pend_tok_d;
  logic                 pend_v_q, pend_v_d;
  logic                 wp_q, wp_d;          // deferred write of entry 0
  logic [7:0]           wp_data_q, wp_data_d;

  // output register
  logic                 o_valid_q, o_valid_d;
  tok_t                 o_tok_q, o_tok_d;
  logic [7:0]           o_tch_q, o_tch_d;
  logic                 o_tv_q, o_tv_d;
  logic                 o_tlast_q, o_tlast_d;
  logic                 o_ilast_q, o_ilast_d;

  logic       slot_free, accept, eof;
  logic [7:0] c;

  // text RAM
  logic              ram_we, ram_re;
  logic [TXT_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata, ram_rdata;

  assign c         = s_axis_tdata;
  assign eof       = s_axis_tlast;
  assign slot_free = !o_valid_q || m_axis_tready;
  assign s_axis_tready = (mode_q == M_IDLE) && slot_free;
  assign accept    = s_axis_tvalid && s_axis_tready;

  // character classes
  logic is_alpha, is_digit, is_print, is_ws, is_idch;
  assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_digit = c >= "0" && c <= "9";
  assign is_print = c >= 8'h20 && c <= 8'h7E;
  assign is_ws    = c == " " || c == 8'h09 || c == 8'h0A;
  assign is_idch  = is_alpha || is_digit || c == "_";

  // keyword match tracking, one bit per keyword
  logic [15:0] kw_init, kw_next;
  logic        kw_hit;
  logic [3:0]  kw_idx;
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      kw_init[k] = kw_char(4'(k), 3'd0) == c;
      kw_next[k] = kwm_q[k] && (tl_q < TXT_LEN_W'(7)) && (kw_char(4'(k), tl_q[2:0]) == c);
      if (kwm_q[k] && (TXT_LEN_W'(kw_len(4'(k))) == tl_q)) begin
        kw_hit = 1'b1;
        kw_idx = 4'(k);
      end
    end
  end

  // saturating decimal accumulate
  logic [34:0] acc_mul;
  logic [30:0] acc_sat;
  assign acc_mul = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + {31'd0, c[3:0]};
  assign acc_sat = (acc_mul > {4'd0, INT_SAT}) ? INT_SAT : acc_mul[30:0];

  // start-state action, used on a fresh byte and on a reprocessed one
  scan_e s_st;
  tok_t  s_tok;
  logic  s_tok_v, s_push, s_acc_load, s_tl_clr, s_acc_clr;
  always_comb begin
    s_st = S_START;
    s_tok = '0;
    s_tok_v = 1'b0;
    s_push = 1'b0;
    s_acc_load = 1'b0;
    s_tl_clr = 1'b0;
    s_acc_clr = 1'b0;
    if (eof) begin
      s_tok = tok_kind(K_END);
      s_tok_v = 1'b1;
    end else if (is_ws) begin
      s_st = S_START;
    end else if (is_alpha) begin
      s_push = 1'b1;
      s_st = S_IDENT;
    end else if (is_digit) begin
      s_push = 1'b1;
      s_acc_load = 1'b1;
      s_st = S_INT;
    end else begin
      s_tok_v = 1'b1;
      case (c)
        "{": s_tok = tok_sym(Y_LBRACE);
        "}": s_tok = tok_sym(Y_RBRACE);
        "(": s_tok = tok_sym(Y_LPAREN);
        ")": s_tok = tok_sym(Y_RPAREN);
        "[": s_tok = tok_sym(Y_LBRACK);
        "]": s_tok = tok_sym(Y_RBRACK);
        ".": s_tok = tok_sym(Y_DOT);
        ",": s_tok = tok_sym(Y_COMMA);
        ";": s_tok = tok_sym(Y_SEMI);
        "^": s_tok = tok_sym(Y_CARET);
        "~": s_tok = tok_sym(Y_TILDE);
        "*": s_tok = tok_sym(Y_STAR);
        "-": s_tok = tok_sym(Y_MINUS);
        "+": s_tok = tok_sym(Y_PLUS);
        CH_QUOTE: begin s_tok_v = 1'b0; s_tl_clr = 1'b1; s_st = S_STR; end
        CH_APOS:  begin s_tok_v = 1'b0; s_st = S_CH_OPEN; end
        ">": begin s_tok_v = 1'b0; s_st = S_GT; end
        "<": begin s_tok_v = 1'b0; s_st = S_LT; end
        "&": begin s_tok_v = 1'b0; s_st = S_AMP; end
        "|": begin s_tok_v = 1'b0; s_st = S_BAR; end
        ":": begin s_tok_v = 1'b0; s_st = S_COLON; end
        "!": begin s_tok_v = 1'b0; s_st = S_BANG; end
        "=": begin s_tok_v = 1'b0; s_st = S_EQ; end
        "/": begin s_tok_v = 1'b0; s_st = S_SLASH; end
        default: begin
          s_tok = tok_err(E_INVALID);
          s_tl_clr = 1'b1;
          s_acc_clr = 1'b1;
        end
      endcase
    end
  end

  // lexer step: first pass on the current state, second pass in start state
  tok_t                 r1, r2;
  logic                 r1_v, r1_run, r2_v, reproc;
  logic                 p1_push, p2_push, push_ok;
  logic [TXT_LEN_W-1:0] r1_len;
  logic                 pair_hit;
  logic [4:0]           pair_yes, pair_no;
  always_comb begin
    n_st = scan_q;
    n_tl = tl_q;
    n_acc = acc_q;
    n_held = held_q;
    n_lit = lit_q;
    n_kwm = kwm_q;
    r1 = '0;
    r1_v = 1'b0;
    r1_run = 1'b0;
    r1_len = tl_q;
    r2 = '0;
    r2_v = 1'b0;
    reproc = 1'b0;
    p1_push = 1'b0;
    p2_push = 1'b0;
    push_ok = tl_q < TXT_LEN_W'(MAX_TEXT);
    pair_hit = 1'b0;
    pair_yes = Y_GE;
    pair_no = Y_GT;

    case (scan_q)
      S_START: begin
        n_st = s_st;
        r1 = s_tok;
        r1_v = s_tok_v;
        if (s_push) begin
          p1_push = 1'b1;
          n_tl = TXT_LEN_W'(1);
          n_kwm = kw_init;
        end
        if (s_acc_load) n_acc = {27'd0, c[3:0]};
        if (s_tl_clr) n_tl = '0;
        if (s_acc_clr) n_acc = '0;
      end
      S_IDENT, S_FLOAT: begin
        if (!eof && ((scan_q == S_IDENT) ? is_idch : is_digit)) begin
          if (push_ok) begin
            p1_push = 1'b1;
            n_tl = tl_q + TXT_LEN_W'(1);
            n_kwm = kw_next;
          end else begin
            r1 = tok_err(E_LONG); r1_v = 1'b1;
            n_st = S_START; n_tl = '0; n_acc = '0;
          end
        end else begin
          r1_v = 1'b1;
          if (scan_q == S_IDENT && kw_hit) begin
            r1 = tok_kind(K_KWORD);
            r1.kw = kw_idx;
          end else begin
            r1 = tok_kind((scan_q == S_IDENT) ? K_IDENT : K_FLOAT);
            r1_run = 1'b1;
          end
          n_st = S_START;
          reproc = 1'b1;
        end
      end
      S_INT: begin
        if (!eof && (is_digit || c == ".")) begin
          if (push_ok) begin
            p1_push = 1'b1;
            n_tl = tl_q + TXT_LEN_W'(1);
            if (is_digit) n_acc = acc_sat;
            else n_st = S_FDOT;
          end else begin
            r1 = tok_err(E_LONG); r1_v = 1'b1;
            n_st = S_START; n_tl = '0; n_acc = '0;
          end
        end else begin
          r1 = tok_kind(K_INT);
          r1.ival = acc_q;
          r1_v = 1'b1;
          n_st = S_START;
          reproc = 1'b1;
        end
      end
      S_FDOT: begin
        r1_v = 1'b1;
        n_st = S_START; n_tl = '0; n_acc = '0;
        if (eof || !is_digit) begin
          r1 = tok_err(E_INVALID);
          if (eof) begin r2 = tok_kind(K_END); r2_v = 1'b1; end
        end else if (push_ok) begin
          r1_v = 1'b0;
          p1_push = 1'b1;
          n_tl = tl_q + TXT_LEN_W'(1);
          n_acc = acc_q;
          n_st = S_FLOAT;
        end else begin
          r1 = tok_err(E_LONG);
        end
      end
      S_STR: begin
        if (eof) begin
          r1 = tok_err(E_EOF); r1_v = 1'b1;
          r2 = tok_kind(K_END); r2_v = 1'b1;
          n_st = S_START; n_tl = '0; n_acc = '0;
        end else if (c == CH_QUOTE) begin
          r1 = tok_kind(K_STRING);
          r1.lit = lit_q;
          r1_v = 1'b1;
          r1_run = tl_q != '0;   // an empty string is a single result
          n_lit = lit_q + 16'd1;
          n_st = S_START;
        end else if (!is_print || !push_ok) begin
          r1 = tok_err(is_print ? E_LONG : E_INVALID); r1_v = 1'b1;
          n_st = S_START; n_tl = '0; n_acc = '0;
        end else begin
          p1_push = 1'b1;
          n_tl = tl_q + TXT_LEN_W'(1);
        end
      end
      S_CH_OPEN, S_CH_ESC, S_CH_HELD, S_CH_NL, S_CH_NUL: begin
        if (eof) begin
          r1 = tok_err(E_EOF); r1_v = 1'b1;
          r2 = tok_kind(K_END); r2_v = 1'b1;
          n_st = S_START; n_tl = '0; n_acc = '0;
        end else if (scan_q == S_CH_OPEN && c == CH_BSL) begin
          n_st = S_CH_ESC;
        end else if (scan_q == S_CH_OPEN && is_print && c != CH_APOS) begin
          n_held = c;
          n_st = S_CH_HELD;
        end else if (scan_q == S_CH_ESC && c == "n") begin
          n_st = S_CH_NL;
        end else if (scan_q == S_CH_ESC && c == "0") begin
          n_st = S_CH_NUL;
        end else if (scan_q != S_CH_OPEN && scan_q != S_CH_ESC && c == CH_APOS) begin
          r1_v = 1'b1;
          if (scan_q == S_CH_HELD) begin
            r1 = tok_kind(K_CHAR); r1.ch = held_q;
          end else if (scan_q == S_CH_NL) begin
            r1 = tok_kind(K_NLCHAR); r1.ch = 8'h0A;
          end else begin
            r1 = tok_kind(K_NULCH);
          end
          n_st = S_START;
        end else begin
          r1 = tok_err(E_INVALID); r1_v = 1'b1;
          n_st = S_START; n_tl = '0; n_acc = '0;
        end
      end
      S_GT, S_LT, S_AMP, S_COLON, S_BANG, S_EQ: begin
        case (scan_q)
          S_LT:    begin pair_hit = c == "=";  pair_yes = Y_LE;    pair_no = Y_LT;    end
          S_AMP:   begin pair_hit = c == "&";  pair_yes = Y_AND;   pair_no = Y_AMP;   end
          S_COLON: begin pair_hit = c == ":";  pair_yes = Y_SCOPE; pair_no = Y_COLON; end
          S_BANG:  begin pair_hit = c == "=";  pair_yes = Y_NE;    pair_no = Y_BANG;  end
          S_EQ:    begin pair_hit = c == "=";  pair_yes = Y_EQ;    pair_no = Y_ASSIGN; end
          default: begin pair_hit = c == "=";  pair_yes = Y_GE;    pair_no = Y_GT;    end
        endcase
        n_st = S_START;
        r1_v = 1'b1;
        if (!eof && pair_hit) begin
          r1 = tok_sym(pair_yes);
        end else begin
          r1 = tok_sym(pair_no);
          reproc = 1'b1;
        end
      end
      S_BAR: begin
        r1_v = 1'b1;
        n_st = S_START;
        if (eof || c != "|") begin
          r1 = tok_err(E_INVALID);
          n_tl = '0; n_acc = '0;
          if (eof) begin r2 = tok_kind(K_END); r2_v = 1'b1; end
        end else begin
          r1 = tok_sym(Y_OR);
        end
      end
      S_SLASH: begin
        if (!eof && c == "*") begin
          n_st = S_CMT;
        end else begin
          r1 = tok_sym(Y_SLASH); r1_v = 1'b1;
          n_st = S_START;
          reproc = 1'b1;
        end
      end
      S_CMT, S_CMT_STAR: begin
        if (eof) begin
          r1 = tok_err(E_EOF); r1_v = 1'b1;
          r2 = tok_kind(K_END); r2_v = 1'b1;
          n_st = S_START; n_tl = '0; n_acc = '0;
        end else if (c == "*") begin
          n_st = S_CMT_STAR;
        end else if (scan_q == S_CMT_STAR && c == "/") begin
          n_st = S_START;
        end else begin
          n_st = S_CMT;
        end
      end
      default: n_st = S_START;
    endcase

    // the byte that ended a token starts the next one
    if (reproc) begin
      n_st = s_st;
      r2 = s_tok;
      r2_v = s_tok_v;
      if (s_push) begin
        p2_push = 1'b1;
        n_tl = TXT_LEN_W'(1);
        n_kwm = kw_init;
      end
      if (s_acc_load) n_acc = {27'd0, c[3:0]};
      if (s_tl_clr) n_tl = '0;
      if (s_acc_clr) n_acc = '0;
    end
  end

  // sequencer and output register
  logic idx_last;
  assign idx_last = TXT_LEN_W'(idx_q) == run_len_q - TXT_LEN_W'(1);

  always_comb begin
    mode_d = mode_q;
    run_tok_d = run_tok_q;
    run_len_d = run_len_q;
    idx_d = idx_q;
    pend_tok_d = pend_tok_q;
    pend_v_d = pend_v_q;
    wp_d = wp_q;
    wp_data_d = wp_data_q;
    o_valid_d = o_valid_q && !m_axis_tready;
    o_tok_d = o_tok_q;
    o_tch_d = o_tch_q;
    o_tv_d = o_tv_q;
    o_tlast_d = o_tlast_q;
    o_ilast_d = o_ilast_q;
    ram_we = 1'b0;
    ram_waddr = '0;
    ram_wdata = c;
    ram_re = 1'b0;

    case (mode_q)
      M_IDLE: begin
        if (accept) begin
          // a token opened in the start state writes entry 0;
          // second-pass write must wait until the old run has been read out
          if (p1_push || (p2_push && !r1_run)) begin
            ram_we = 1'b1;
            ram_waddr = (p1_push && scan_q != S_START) ? tl_q[TXT_AW-1:0] : '0;
          end
          pend_tok_d = r2;
          pend_v_d = r2_v;
          if (r1_run) begin
            run_tok_d = r1;
            run_len_d = r1_len;
            idx_d = '0;
            wp_d = p2_push;
            wp_data_d = c;
            mode_d = M_READ;
          end else if (r1_v || r2_v) begin
            o_valid_d = 1'b1;
            o_tok_d = r1_v ? r1 : r2;
            o_tch_d = '0;
            o_tv_d = 1'b0;
            o_tlast_d = 1'b1;
            o_ilast_d = !(r1_v && r2_v);
            if (r1_v && r2_v) mode_d = M_PEND;
          end
        end
      end
      M_READ: begin
        ram_re = 1'b1;
        mode_d = M_WAIT;
      end
      M_WAIT: begin
        if (slot_free) begin
          o_valid_d = 1'b1;
          o_tok_d = run_tok_q;
          o_tch_d = ram_rdata;
          o_tv_d = 1'b1;
          o_tlast_d = idx_last;
          o_ilast_d = idx_last && !pend_v_q;
          if (idx_last) begin
            if (wp_q) begin
              ram_we = 1'b1;
              ram_waddr = '0;
              ram_wdata = wp_data_q;
              wp_d = 1'b0;
            end
            mode_d = pend_v_q ? M_PEND : M_IDLE;
          end else begin
            idx_d = idx_q + TXT_AW'(1);
            mode_d = M_READ;
          end
        end
      end
      M_PEND: begin
        if (slot_free) begin
          o_valid_d = 1'b1;
          o_tok_d = pend_tok_q;
          o_tch_d = '0;
          o_tv_d = 1'b0;
          o_tlast_d = 1'b1;
          o_ilast_d = 1'b1;
          pend_v_d = 1'b0;
          mode_d = M_IDLE;
        end
      end
      default: mode_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      scan_q <= S_START;
      tl_q <= '0;
      acc_q <= '0;
      held_q <= '0;
      lit_q <= '0;
      kwm_q <= '0;
      pend_v_q <= 1'b0;
      wp_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      if (accept) begin
        scan_q <= n_st;
        tl_q <= n_tl;
        acc_q <= n_acc;
        held_q <= n_held;
        lit_q <= n_lit;
        kwm_q <= n_kwm;
      end
      pend_v_q <= pend_v_d;
      wp_q <= wp_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_tok_q <= run_tok_d;
    run_len_q <= run_len_d;
    idx_q <= idx_d;
    pend_tok_q <= pend_tok_d;
    wp_data_q <= wp_data_d;
    o_tok_q <= o_tok_d;
    o_tch_q <= o_tch_d;
    o_tv_q <= o_tv_d;
    o_tlast_q <= o_tlast_d;
    o_ilast_q <= o_ilast_d;
  end

  lts_ram #(
    .Width(8),
    .Depth(MAX_TEXT)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tuser  = o_tok_q.kind;
  assign m_axis_tlast  = o_tlast_q;
  assign m_axis_tdata  = {4'd0, o_ilast_q, o_tok_q.err, o_tv_q, o_tch_q, o_tok_q.lit,
                          o_tok_q.ch, o_tok_q.kw, o_tok_q.ival, o_tok_q.sym};

  `LTS_ASSERT(a_len_bound, tl_q <= TXT_LEN_W'(MAX_TEXT), "text length beyond buffer")
  `LTS_ASSERT(a_defer_in_run, !wp_q || mode_q == M_READ || mode_q == M_WAIT, "stray deferred write")
  `LTS_ASSERT(a_run_index, !(mode_q == M_WAIT) || TXT_LEN_W'(idx_q) < run_len_q, "run index past length")
  `LTS_ASSERT_NEXT(a_wait_stall, mode_q == M_WAIT && !slot_free, mode_q == M_WAIT, "run step lost on stall")

endmodule
